// ----- design/afld_pkg.sv -----
// package: sizes, state type and result record of the audio frame level detector
package afld_pkg;

    localparam int FRAME_SAMPLES = 256;

    localparam int RAW_W  = 32;
    localparam int PCM_W  = 16;
    localparam int REG_W  = 16;
    localparam int CIDX_W = 2;
    localparam int SUM_W  = $clog2(FRAME_SAMPLES * 32768 + 1);
    localparam int CNT_W  = $clog2(FRAME_SAMPLES + 1);
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [REG_W-1:0] TICK_MAX = {REG_W{1'b1}};

    localparam logic [REG_W-1:0] ON_THR_RST  = REG_W'(1200);
    localparam logic [REG_W-1:0] OFF_THR_RST = REG_W'(700);
    localparam logic [REG_W-1:0] HOLD_RST    = REG_W'(180);

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ON_THR  = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_OFF_THR = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] CFG_HOLD    = CIDX_W'(2);

    // action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic signed [PCM_W-1:0] pcm_sample;
        logic                    frame_valid;
        logic [PCM_W-1:0]        frame_peak;
        logic [PCM_W-1:0]        frame_mean_abs;
        logic                    activity_on;
    } t_result;

endpackage

// ----- design/afld_if.sv -----
// channel interfaces: sample/tick input, result output and configuration write
interface afld_in_if;
    import afld_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic signed [RAW_W-1:0] raw_word;
    logic                    frame_end;
    modport source (output valid, action, raw_word, frame_end, input ready);
    modport sink   (input valid, action, raw_word, frame_end, output ready);
endinterface

interface afld_out_if;
    import afld_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [PCM_W-1:0] pcm_sample;
    logic                    frame_valid;
    logic [PCM_W-1:0]        frame_peak;
    logic [PCM_W-1:0]        frame_mean_abs;
    logic                    activity_on;
    modport source (output valid, pcm_sample, frame_valid, frame_peak, frame_mean_abs,
                    activity_on, input ready);
    modport sink   (input valid, pcm_sample, frame_valid, frame_peak, frame_mean_abs,
                    activity_on, output ready);
endinterface

interface afld_cfg_if;
    import afld_pkg::*;
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [REG_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/audio_frame_level_detector_top.sv -----
// audio frame level detector: per-frame peak and mean with a held activity flag
// results: a non-closing sample has its result registered in the cycle after acceptance;
// a frame-closing sample gives its result once the one-bit-per-cycle restoring divider
// that forms the mean has produced its last quotient bit. ticks give no result.
// throughput: 1 item per cycle outside frame end with o_res ready; stalls while dividing.
// reset: synchronous active-low i_rst_n clears the sequencer, statistics, flag and counter
// and loads the threshold and hold registers with their defaults.
module audio_frame_level_detector_top (
    input logic i_clk,
    input logic i_rst_n,
    afld_in_if.sink    i_in,
    afld_out_if.source o_res,
    afld_cfg_if.sink   i_cfg
);
    import afld_pkg::*;

    t_state r_state, n_state;

    logic [REG_W-1:0] r_on_thr, r_off_thr, r_hold;

    logic [PCM_W-1:0] r_peak;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic             r_active;
    logic [REG_W-1:0] r_ticks;

    // divider and the frame record it works on
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_divisor;
    logic [STEP_W-1:0] r_step;
    logic [PCM_W-1:0]  r_fpeak;
    logic signed [PCM_W-1:0] r_fpcm;

    t_result r_out;
    logic    r_out_valid;

    logic in_take, out_take, is_tick, is_sample, closes, div_busy, div_last;
    logic signed [PCM_W-1:0] pcm;
    logic [PCM_W-1:0] mag;
    logic [PCM_W-1:0] n_peak;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W:0]   trial;
    logic             q_bit;
    logic [CNT_W-1:0] n_rem;
    logic [PCM_W-1:0] mean;
    logic             trig, n_active, clr_ticks;

    assign i_cfg.ready = 1'b1;

    assign out_take  = r_out_valid && o_res.ready;
    assign in_take   = i_in.valid && i_in.ready;
    assign is_tick   = (i_in.action == ACT_TICK);
    assign is_sample = in_take && (i_in.action == ACT_SAMPLE);

    // sample datapath
    assign pcm    = i_in.raw_word[RAW_W-1 -: PCM_W];
    assign mag    = pcm[PCM_W-1] ? (~pcm + PCM_W'(1)) : pcm;
    assign n_peak = (mag > r_peak) ? mag : r_peak;
    assign n_sum  = r_sum + SUM_W'(mag);
    assign n_cnt  = r_cnt + CNT_W'(1);
    assign closes = i_in.frame_end || (n_cnt >= CNT_W'(FRAME_SAMPLES));

    // restoring divide step
    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign q_bit = (trial >= {1'b0, r_divisor});
    assign n_rem = q_bit ? CNT_W'(trial - {1'b0, r_divisor}) : CNT_W'(trial);
    assign mean  = PCM_W'({r_quo[SUM_W-2:0], q_bit});

    // activity update at frame end
    assign trig = (r_fpeak >= r_on_thr) || (mean >= (r_on_thr >> 1));
    always_comb begin
        n_active  = r_active;
        clr_ticks = 1'b0;
        if (trig) begin
            n_active  = 1'b1;
            clr_ticks = 1'b1;
        end else if (r_active) begin
            if (r_fpeak > r_off_thr) begin
                clr_ticks = 1'b1;
            end else if (r_ticks >= r_hold) begin
                n_active = 1'b0;
            end
        end
    end

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (is_sample && closes) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_step == LAST_STEP) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        i_in.ready = 1'b0;
        div_busy   = 1'b0;
        div_last   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = !r_out_valid || o_res.ready;
            end
            ST_DIV: begin
                div_busy = 1'b1;
                div_last = (r_step == LAST_STEP);
            end
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_on_thr  <= ON_THR_RST;
            r_off_thr <= OFF_THR_RST;
            r_hold    <= HOLD_RST;
            r_peak    <= '0;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_active  <= 1'b0;
            r_ticks   <= '0;
            r_step    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_ON_THR:  r_on_thr  <= i_cfg.data;
                    CFG_OFF_THR: r_off_thr <= i_cfg.data;
                    CFG_HOLD:    r_hold    <= i_cfg.data;
                    default: ;
                endcase
            end
            if (in_take && is_tick && (r_ticks < TICK_MAX)) begin
                r_ticks <= r_ticks + REG_W'(1);
            end
            if (is_sample) begin
                if (closes) begin
                    r_peak <= '0;
                    r_sum  <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_peak <= n_peak;
                    r_sum  <= n_sum;
                    r_cnt  <= n_cnt;
                end
            end
            if (div_busy) begin
                r_step <= div_last ? '0 : r_step + STEP_W'(1);
            end
            if (div_last) begin
                r_active <= n_active;
                if (clr_ticks) begin
                    r_ticks <= '0;
                end
            end
            if ((is_sample && !closes) || div_last) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (is_sample && closes) begin
            r_quo     <= n_sum;
            r_rem     <= '0;
            r_divisor <= n_cnt;
            r_fpeak   <= n_peak;
            r_fpcm    <= pcm;
        end else if (div_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
        if (is_sample && !closes) begin
            r_out.pcm_sample     <= pcm;
            r_out.frame_valid    <= 1'b0;
            r_out.frame_peak     <= '0;
            r_out.frame_mean_abs <= '0;
            r_out.activity_on    <= r_active;
        end else if (div_last) begin
            r_out.pcm_sample     <= r_fpcm;
            r_out.frame_valid    <= 1'b1;
            r_out.frame_peak     <= r_fpeak;
            r_out.frame_mean_abs <= mean;
            r_out.activity_on    <= n_active;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.pcm_sample     = r_out.pcm_sample;
    assign o_res.frame_valid    = r_out.frame_valid;
    assign o_res.frame_peak     = r_out.frame_peak;
    assign o_res.frame_mean_abs = r_out.frame_mean_abs;
    assign o_res.activity_on    = r_out.activity_on;

`ifndef SYNTH
    a_no_take_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !i_in.ready)
        else $error("input taken while divider busy");

    a_close_starts_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_sample && closes) |=> (r_state == ST_DIV) && (r_step == '0))
        else $error("frame close did not start the divider");

    a_mean_below_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_valid) |-> (r_out.frame_mean_abs <= r_out.frame_peak))
        else $error("frame mean above frame peak");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(FRAME_SAMPLES))
        else $error("sample count reached frame size without closing");
`endif

endmodule

// ----- tb/tb_audio_frame_level_detector_top.sv -----
// testbench: directed table and random traffic checked against a frame level predictor
`timescale 1ns / 100ps

module tb_audio_frame_level_detector_top;
    import afld_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES = 5;
    localparam int PHASE_ITEMS = 80;
    localparam int LONG_FRAME = 260;
    localparam int LONG_HOLD = 500;

    // index past the register list, writes to it must change nothing
    localparam logic [CIDX_W-1:0] CFG_SPARE = CIDX_W'(3);

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic              action;
        logic [RAW_W-1:0]  raw;
        logic              last;
        logic [16:0]       reps;
        logic [CIDX_W-1:0] cfg_idx;
        logic [REG_W-1:0]  cfg_data;
        logic              typed;
        t_result           want;
    } t_stim_row;

    localparam int N_DIRECTED = 25;

    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        // full-scale negative word alone in a frame
        '{ROW_ITEM, ACT_SAMPLE, 32'h8000_0000, 1'b1, 17'd1, CFG_ON_THR, 16'h0000, 1'b1,
          '{16'h8000, 1'b1, 16'h8000, 16'h8000, 1'b1}},
        '{ROW_ITEM, ACT_SAMPLE, 32'h7FFF_FFFF, 1'b0, 17'd1, CFG_ON_THR, 16'h0000, 1'b1,
          '{16'h7FFF, 1'b0, 16'h0000, 16'h0000, 1'b1}},
        '{ROW_ITEM, ACT_SAMPLE, 32'hFFFF_FFFF, 1'b1, 17'd1, CFG_ON_THR, 16'h0000, 1'b1,
          '{16'hFFFF, 1'b1, 16'h7FFF, 16'h4000, 1'b1}},
        // low half of the word is dropped, silent frame keeps the flag on
        '{ROW_ITEM, ACT_SAMPLE, 32'h0000_FFFF, 1'b1, 17'd1, CFG_ON_THR, 16'h0000, 1'b1,
          '{16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b1}},
        '{ROW_ITEM, ACT_TICK, 32'h1234_5678, 1'b1, 17'd3, CFG_ON_THR, 16'h0000, 1'b0, '0},
        '{ROW_CFG, ACT_SAMPLE, 32'h0, 1'b0, 17'd1, CFG_HOLD, 16'h0000, 1'b0, '0},
        // zero hold: quiet frame turns the flag off
        '{ROW_ITEM, ACT_SAMPLE, 32'h0001_0000, 1'b1, 17'd1, CFG_ON_THR, 16'h0000, 1'b1,
          '{16'h0001, 1'b1, 16'h0001, 16'h0001, 1'b0}},
        '{ROW_CFG, ACT_SAMPLE, 32'h0, 1'b0, 17'd1, CFG_ON_THR, 16'h0000, 1'b0, '0},
        '{ROW_ITEM, ACT_SAMPLE, 32'hFFFF_0000, 1'b1, 17'd1, CFG_ON_THR, 16'h0000, 1'b1,
          '{16'hFFFF, 1'b1, 16'h0001, 16'h0001, 1'b1}},
        '{ROW_CFG, ACT_SAMPLE, 32'h0, 1'b0, 17'd1, CFG_ON_THR, 16'h8000, 1'b0, '0},
        '{ROW_CFG, ACT_SAMPLE, 32'h0, 1'b0, 17'd1, CFG_OFF_THR, 16'h0000, 1'b0, '0},
        '{ROW_CFG, ACT_SAMPLE, 32'h0, 1'b0, 17'd1, CFG_HOLD, 16'h0002, 1'b0, '0},
        '{ROW_CFG, ACT_SAMPLE, 32'h0, 1'b0, 17'd1, CFG_SPARE, 16'hFFFF, 1'b0, '0},
        '{ROW_ITEM, ACT_TICK, 32'hEDCB_A987, 1'b0, 17'd2, CFG_ON_THR, 16'h0000, 1'b0, '0},
        // peak above the off level refreshes the hold
        '{ROW_ITEM, ACT_SAMPLE, 32'h0002_0000, 1'b1, 17'd1, CFG_ON_THR, 16'h0000, 1'b1,
          '{16'h0002, 1'b1, 16'h0002, 16'h0002, 1'b1}},
        '{ROW_ITEM, ACT_TICK, 32'h0000_0000, 1'b0, 17'd2, CFG_ON_THR, 16'h0000, 1'b0, '0},
        '{ROW_ITEM, ACT_SAMPLE, 32'h0000_0000, 1'b1, 17'd1, CFG_ON_THR, 16'h0000, 1'b1,
          '{16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b0}},
        // frame closed by size, mean lands exactly on half the on level
        '{ROW_ITEM, ACT_SAMPLE, 32'hC000_0000, 1'b0, 17'd256, CFG_ON_THR, 16'h0000, 1'b0, '0},
        '{ROW_ITEM, ACT_SAMPLE, 32'h8000_0000, 1'b1, 17'd1, CFG_ON_THR, 16'h0000, 1'b1,
          '{16'h8000, 1'b1, 16'h8000, 16'h8000, 1'b1}},
        '{ROW_CFG, ACT_SAMPLE, 32'h0, 1'b0, 17'd1, CFG_ON_THR, 16'hFFFF, 1'b0, '0},
        '{ROW_CFG, ACT_SAMPLE, 32'h0, 1'b0, 17'd1, CFG_OFF_THR, 16'hFFFF, 1'b0, '0},
        '{ROW_CFG, ACT_SAMPLE, 32'h0, 1'b0, 17'd1, CFG_HOLD, 16'hFFFF, 1'b0, '0},
        // tick counter must stop at its ceiling to reach the longest hold
        '{ROW_ITEM, ACT_TICK, 32'h0000_0000, 1'b0, 17'd65600, CFG_ON_THR, 16'h0000, 1'b0, '0},
        '{ROW_ITEM, ACT_SAMPLE, 32'h0000_0000, 1'b1, 17'd1, CFG_ON_THR, 16'h0000, 1'b1,
          '{16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b0}},
        '{ROW_ITEM, ACT_SAMPLE, 32'h8000_0000, 1'b1, 17'd1, CFG_ON_THR, 16'h0000, 1'b1,
          '{16'h8000, 1'b1, 16'h8000, 16'h8000, 1'b1}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    afld_in_if  in_ch ();
    afld_out_if res_ch ();
    afld_cfg_if cfg_ch ();

    audio_frame_level_detector_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor copy of registers and frame statistics
    logic [REG_W-1:0] reg_on_thr;
    logic [REG_W-1:0] reg_off_thr;
    logic [REG_W-1:0] reg_hold;
    logic [PCM_W-1:0] acc_peak;
    logic [SUM_W-1:0] acc_sum;
    logic [CNT_W-1:0] acc_count;
    logic             act_flag;
    logic [REG_W-1:0] tick_count;

    t_result pending_results [$];
    int      bad_results = 0;
    int      cycle_count = 0;
    bit      send_calm = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** audio_frame_level_detector_top: FAILED **");
            $finish;
        end
    end

    function automatic t_result predict_level_result(input logic [RAW_W-1:0] raw,
                                                     input logic last);
        logic [PCM_W-1:0] hi;
        logic [PCM_W-1:0] mag;
        logic [PCM_W-1:0] peak;
        logic [SUM_W-1:0] mean;
        logic             trig;
        t_result          r;
        hi = raw[RAW_W-1 -: PCM_W];
        mag = hi[PCM_W-1] ? PCM_W'(~hi + 1'b1) : hi;
        if (mag > acc_peak) acc_peak = mag;
        acc_sum = acc_sum + SUM_W'(mag);
        acc_count = acc_count + CNT_W'(1);
        r = '0;
        r.pcm_sample = hi;
        if (last || acc_count >= CNT_W'(FRAME_SAMPLES)) begin
            peak = acc_peak;
            mean = acc_sum / SUM_W'(acc_count);
            trig = (peak >= reg_on_thr) || (mean >= SUM_W'(reg_on_thr >> 1));
            if (trig) begin
                act_flag = 1'b1;
                tick_count = '0;
            end else if (act_flag && peak > reg_off_thr) begin
                tick_count = '0;
            end else if (act_flag && tick_count >= reg_hold) begin
                act_flag = 1'b0;
            end
            r.frame_valid = 1'b1;
            r.frame_peak = peak;
            r.frame_mean_abs = mean[PCM_W-1:0];
            acc_peak = '0;
            acc_sum = '0;
            acc_count = '0;
        end
        r.activity_on = act_flag;
        return r;
    endfunction

    function automatic int sender_gap();
        if ($urandom_range(0, 24) == 0) send_calm = !send_calm;
        return send_calm ? 0 : $urandom_range(0, 18);
    endfunction

    // mix of levels around the current on threshold, full range, extremes and near silence
    function automatic logic [RAW_W-1:0] draw_sample_word();
        logic [PCM_W-1:0] hi;
        int unsigned      lim;
        int unsigned      mag;
        lim = (reg_on_thr > 16384) ? 32768 : 2 * reg_on_thr + 8;
        case ($urandom_range(0, 9)) inside
            [0:3]: begin
                mag = $urandom_range(0, lim);
                hi = $urandom_range(0, 1) ? PCM_W'(0 - mag) : PCM_W'(mag);
            end
            [4:5]: hi = PCM_W'($urandom);
            6: begin
                case ($urandom_range(0, 3))
                    0: hi = 16'h8000;
                    1: hi = 16'h7FFF;
                    2: hi = 16'h0000;
                    default: hi = 16'hFFFF;
                endcase
            end
            default: hi = PCM_W'(int'($urandom_range(0, 128)) - 64);
        endcase
        return {hi, (RAW_W-PCM_W)'($urandom)};
    endfunction

    task automatic send_item(input logic act, input logic [RAW_W-1:0] raw, input logic last,
                             input int gap, input logic typed, input t_result want);
        t_result predicted;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.raw_word <= raw;
        in_ch.frame_end <= last;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        if (act == ACT_TICK) begin
            if (tick_count != TICK_MAX) tick_count = tick_count + REG_W'(1);
        end else begin
            predicted = predict_level_result(raw, last);
            pending_results.push_back(typed ? want : predicted);
        end
    endtask

    // stop requests, let every result drain and the block go idle
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [REG_W-1:0] val);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        case (idx)
            CFG_ON_THR:  reg_on_thr = val;
            CFG_OFF_THR: reg_off_thr = val;
            CFG_HOLD:    reg_hold = val;
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        bad_results++;
        if (bad_results <= 10) begin
            $display("cycle %0d %s: expected pcm %0d fv %0b peak %0d mean %0d act %0b",
                     cycle_count, what, want.pcm_sample, want.frame_valid, want.frame_peak,
                     want.frame_mean_abs, want.activity_on);
            $display("    actual pcm %0d fv %0b peak %0d mean %0d act %0b",
                     got.pcm_sample, got.frame_valid, got.frame_peak, got.frame_mean_abs,
                     got.activity_on);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.pcm_sample = res_ch.pcm_sample;
            got.frame_valid = res_ch.frame_valid;
            got.frame_peak = res_ch.frame_peak;
            got.frame_mean_abs = res_ch.frame_mean_abs;
            got.activity_on = res_ch.activity_on;
            if (pending_results.size() == 0) begin
                note_mismatch("result with no request waiting", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.pcm_sample !== want.pcm_sample ||
                    got.frame_valid !== want.frame_valid ||
                    got.frame_peak !== want.frame_peak ||
                    got.frame_mean_abs !== want.frame_mean_abs ||
                    got.activity_on !== want.activity_on) begin
                    note_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // result side: random stalls, calm stretches and one long hold-off
    initial begin : result_sink
        int gap;
        int taken;
        bit long_done;
        bit calm;
        taken = 0;
        long_done = 1'b0;
        calm = 1'b0;
        res_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 18);
            if (!long_done && taken == 60) begin
                gap = LONG_HOLD;
                long_done = 1'b1;
            end
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
            taken++;
        end
    end

    initial begin : stimulus
        int               i;
        int               r;
        int               n;
        int               phase;
        int               drain;
        t_stim_row        row;
        logic [REG_W-1:0] on_v;
        logic [REG_W-1:0] off_v;
        logic [REG_W-1:0] hold_v;

        in_ch.valid <= 1'b0;
        in_ch.action <= ACT_SAMPLE;
        in_ch.raw_word <= '0;
        in_ch.frame_end <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_ON_THR;
        cfg_ch.data <= '0;

        reg_on_thr = ON_THR_RST;
        reg_off_thr = OFF_THR_RST;
        reg_hold = HOLD_RST;
        acc_peak = '0;
        acc_sum = '0;
        acc_count = '0;
        act_flag = 1'b0;
        tick_count = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_CFG) begin
                write_reg(row.cfg_idx, row.cfg_data);
            end else begin
                for (r = 0; r < row.reps; r++)
                    send_item(row.action, row.raw, row.last,
                              (row.reps > 300) ? 0 : sender_gap(), row.typed, row.want);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    on_v = REG_W'($urandom_range(400, 3000));
                    off_v = REG_W'($urandom_range(100, 1500));
                    hold_v = REG_W'($urandom_range(0, 8));
                end
                1: begin
                    on_v = '0;
                    off_v = '0;
                    hold_v = '0;
                end
                2: begin
                    on_v = 16'h8000;
                    off_v = 16'h8000;
                    hold_v = 16'hFFFF;
                end
                3: begin
                    on_v = 16'hFFFF;
                    off_v = REG_W'($urandom_range(0, 40000));
                    hold_v = 16'h0001;
                end
                default: begin
                    on_v = REG_W'($urandom_range(200, 2000));
                    off_v = REG_W'($urandom_range(0, 2000));
                    hold_v = REG_W'($urandom_range(0, 30));
                end
            endcase
            write_reg(CFG_ON_THR, on_v);
            write_reg(CFG_OFF_THR, off_v);
            write_reg(CFG_HOLD, hold_v);
            if (phase == 2) write_reg(CFG_SPARE, REG_W'($urandom));

            // a run of samples longer than the frame size with no frame_end flag, so the size limit closes the frame
            if (phase == 3) begin
                for (n = 0; n < LONG_FRAME; n++)
                    send_item(ACT_SAMPLE, draw_sample_word(), 1'b0, sender_gap(), 1'b0, '0);
            end

            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 2 && n == 40) begin
                    in_ch.valid <= 1'b0;
                    do @(posedge i_clk); while (pending_results.size() != 0);
                end
                if ($urandom_range(0, 2) == 0)
                    send_item(ACT_TICK, RAW_W'($urandom), 1'($urandom), sender_gap(),
                              1'b0, '0);
                else
                    send_item(ACT_SAMPLE, draw_sample_word(), $urandom_range(0, 4) == 0,
                              sender_gap(), 1'b0, '0);
            end
        end

        in_ch.valid <= 1'b0;
        drain = 0;
        do begin
            @(posedge i_clk);
            drain++;
        end while (pending_results.size() != 0 && drain < 20000);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (bad_results == 0 && pending_results.size() == 0) begin
            $display("** audio_frame_level_detector_top: PASSED **");
        end else begin
            $display("** audio_frame_level_detector_top: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/afld_pkg.sv
design/afld_if.sv
design/audio_frame_level_detector_top.sv
tb/tb_audio_frame_level_detector_top.sv
